>>> hdl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared action codes, command format, SHA-1 constants and queue sizing.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int unsigned CMD_QUEUE_DEPTH = 4;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_CHAIN  = 5;
  localparam int unsigned SCHED_LEN  = 16;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [1:0] ACT_ABSORB  = 2'd0;
  localparam logic [1:0] ACT_FINISH  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_FILL  = 6'd63;

  typedef enum logic [1:0] {
    CMD_ABSORB,
    CMD_FINISH,
    CMD_RESTART
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] INIT_H [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

endpackage

>>> hdl/sha1sh_cmd_fifo.sv
// ----------------------------------------------------------------------------
// SHA-1 command queue
// Small register queue between the classifying front end and the hash core.
// ----------------------------------------------------------------------------
module sha1sh_cmd_fifo #(
  parameter int unsigned DEPTH = sha1sh_pkg::CMD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  sha1sh_pkg::cmd_t  push_cmd,
  output logic              push_ready,
  output logic              pop_valid,
  output sha1sh_pkg::cmd_t  pop_cmd,
  input  logic              pop_ready
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sha1sh_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/sha1sh_front.sv
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts input transfers, drops ignored ones and queues commands.
// ----------------------------------------------------------------------------
module sha1sh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_data_byte,
  output logic              push_valid,
  output sha1sh_pkg::cmd_t  push_cmd,
  input  logic              push_ready
);

  logic done_r, done_nxt;
  logic accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    done_nxt      = done_r;
    push_valid    = 1'b0;
    push_cmd.op   = sha1sh_pkg::CMD_ABSORB;
    push_cmd.data = in_data_byte;
    if (accept) begin
      if (in_action == sha1sh_pkg::ACT_RESTART) begin
        push_valid  = 1'b1;
        push_cmd.op = sha1sh_pkg::CMD_RESTART;
        done_nxt    = 1'b0;
      end else if (!done_r && in_action == sha1sh_pkg::ACT_ABSORB) begin
        push_valid  = 1'b1;
        push_cmd.op = sha1sh_pkg::CMD_ABSORB;
      end else if (!done_r && in_action == sha1sh_pkg::ACT_FINISH) begin
        push_valid  = 1'b1;
        push_cmd.op = sha1sh_pkg::CMD_FINISH;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

endmodule

>>> hdl/sha1sh_core.sv
// ----------------------------------------------------------------------------
// SHA-1 hash core
// Packs bytes into the schedule window, pads, runs one round per cycle and
// presents the digest words.
// ----------------------------------------------------------------------------
module sha1sh_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  input  sha1sh_pkg::cmd_t  pop_cmd,
  output logic              pop_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  localparam int unsigned NC = sha1sh_pkg::NUM_CHAIN;
  localparam int unsigned NS = sha1sh_pkg::SCHED_LEN;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [31:0] win_r [NS];
  logic [31:0] win_nxt [NS];
  logic [31:0] h_r [NC];
  logic [31:0] h_nxt [NC];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]  round_r, round_nxt;
  logic        mark_r, mark_nxt;
  logic        len_r, len_nxt;
  logic        final_r, final_nxt;
  logic        finishing_r, finishing_nxt;
  logic [2:0]  emit_idx_r, emit_idx_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        push_en;
  logic [7:0]  push_byte;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic [1:0]  stage;
  logic [31:0] f_val, sched_new, t_sum;

  function automatic logic [31:0] sched_new_raw(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  assign pop_ready       = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = h_r[emit_idx_r];
  assign out_word_index  = emit_idx_r;
  assign out_last_word   = (emit_idx_r == 3'(NC - 1));

  assign bit_len  = {total_r, 3'b000};
  assign len_sel  = ~fill_r[2:0];
  assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

  always_comb begin
    if (round_r < 7'd20) begin
      stage = 2'd0;
      f_val = (b_r & c_r) | (~b_r & d_r);
    end else if (round_r < 7'd40) begin
      stage = 2'd1;
      f_val = b_r ^ c_r ^ d_r;
    end else if (round_r < 7'd60) begin
      stage = 2'd2;
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    end else begin
      stage = 2'd3;
      f_val = b_r ^ c_r ^ d_r;
    end
  end

  assign sched_new = {sched_new_raw(win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0])};
  assign t_sum = {a_r[26:0], a_r[31:27]} + f_val + e_r +
                 sha1sh_pkg::ROUND_K[stage] + win_r[0];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    win_nxt       = win_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    round_nxt     = round_r;
    mark_nxt      = mark_r;
    len_nxt       = len_r;
    final_nxt     = final_r;
    finishing_nxt = finishing_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r;
    push_en       = 1'b0;
    push_byte     = 8'h00;

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.op)
            sha1sh_pkg::CMD_ABSORB: begin
              push_en   = 1'b1;
              push_byte = pop_cmd.data;
              total_nxt = total_r + 1'b1;
            end
            sha1sh_pkg::CMD_FINISH: begin
              finishing_nxt = 1'b1;
              mark_nxt      = 1'b1;
              len_nxt       = 1'b0;
              final_nxt     = 1'b0;
              state_nxt     = S_PAD;
            end
            sha1sh_pkg::CMD_RESTART: begin
              h_nxt         = sha1sh_pkg::INIT_H;
              fill_nxt      = '0;
              total_nxt     = '0;
              finishing_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        if (mark_r) begin
          push_byte = sha1sh_pkg::PAD_MARK;
          mark_nxt  = 1'b0;
        end else if (len_r || fill_r == sha1sh_pkg::LEN_OFFSET) begin
          push_byte = len_byte;
          len_nxt   = 1'b1;
          if (fill_r == sha1sh_pkg::LAST_FILL) begin
            final_nxt = 1'b1;
          end
        end
      end
      S_ROUND: begin
        for (int i = 0; i < NS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[NS-1] = sched_new;
        e_nxt     = d_r;
        d_nxt     = c_r;
        c_nxt     = {b_r[1:0], b_r[31:2]};
        b_nxt     = a_r;
        a_nxt     = t_sum;
        round_nxt = round_r + 1'b1;
        if (round_r == 7'(sha1sh_pkg::NUM_ROUNDS - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (final_r) begin
          final_nxt     = 1'b0;
          finishing_nxt = 1'b0;
          emit_idx_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else if (finishing_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (emit_idx_r == 3'(NC - 1)) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push_en) begin
      fill_nxt = fill_r + 1'b1;
      acc_nxt  = {acc_r[15:0], push_byte};
      if (fill_r[1:0] == 2'b11) begin
        for (int i = 0; i < NS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[NS-1] = {acc_r, push_byte};
      end
      if (fill_r == sha1sh_pkg::LAST_FILL) begin
        a_nxt     = h_r[0];
        b_nxt     = h_r[1];
        c_nxt     = h_r[2];
        d_nxt     = h_r[3];
        e_nxt     = h_r[4];
        round_nxt = '0;
        state_nxt = S_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      h_r         <= sha1sh_pkg::INIT_H;
      round_r     <= '0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      final_r     <= 1'b0;
      finishing_r <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      h_r         <= h_nxt;
      round_r     <= round_nxt;
      mark_r      <= mark_nxt;
      len_r       <= len_nxt;
      final_r     <= final_nxt;
      finishing_r <= finishing_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    win_r <= win_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

endmodule

>>> hdl/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Hashes a byte stream; each finish transfer yields a five-word digest.
//
// Input channel (in_valid/in_ready): in_action 0 absorbs in_data_byte,
// 1 pads the message and emits the digest, 2 restarts the hasher; code 3,
// and absorb or finish after a finish, are dropped without result.
// Output channel (out_valid/out_ready): five transfers per finish, word
// index 0 to 4, out_last_word set on index 4.
// Inputs land in a command queue of QUEUE_DEPTH entries, so in_ready only
// drops while the queue is full. The core takes one byte per cycle, but only
// while idle; the 64th byte of a block starts the compression, 80 rounds at
// one per cycle plus one chaining add. A finish appends 9 to 72 padding
// bytes, runs one or two compressions and then presents the digest words.
// A stalled receiver holds the current word steady; the queue keeps taking
// input until it fills.
// Reset restores the initial chaining values, empties the queue and clears
// the byte count; no result is pending afterward.
// ----------------------------------------------------------------------------
module sha1_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha1sh_pkg::CMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  sha1sh_pkg::cmd_t push_cmd, pop_cmd;

  sha1sh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready)
  );

  sha1sh_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  sha1sh_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_cmd         (pop_cmd),
    .pop_ready       (pop_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

>>> hdl/sha1sh_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher checker
// Port-level checks on the digest word sequence.
// ----------------------------------------------------------------------------
module sha1sh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word) &&
      $stable(out_word_index))
    else $error("digest word changed while stalled");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd4)))
    else $error("last_word does not match word index four");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not delivered in order");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid)
    else $error("output valid right after final digest word");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_word_index == 3'd0)
    else $error("digest did not start at word zero");

endmodule

bind sha1_stream_hasher sha1sh_checker u_checker (.*);
